FILE: src/tba_pkg.sv
package tba_pkg;

  localparam int TBA_T_W      = 16;
  localparam int TBA_W_W      = 17;
  localparam int TBA_WS_W     = 35;
  localparam int TBA_PROD_W   = TBA_W_W + TBA_WS_W;
  localparam int TBA_NUM_W    = 51;
  localparam int TBA_DEN_W    = 34;
  localparam int TBA_QUOT_W   = 18;
  localparam int TBA_SH_W     = 19;
  localparam int TBA_CNT_W    = 5;
  localparam int TBA_PASS_W   = 4;
  localparam int TBA_ORDER_PASSES = 10;

  localparam logic [TBA_T_W-1:0] TBA_EQUAL_RST  = 16'd8;
  localparam logic [TBA_T_W-1:0] TBA_FULL_RST   = 16'd32;
  localparam logic [TBA_T_W-1:0] TBA_LIGHT_RST  = 16'd6;
  localparam logic [TBA_T_W-1:0] TBA_STRICT_RST = 16'd9;
  localparam logic [TBA_W_W-1:0] TBA_WC_RST     = 17'd32768;
  localparam logic [TBA_W_W-1:0] TBA_WA_RST     = 17'd13107;
  localparam logic [TBA_W_W-1:0] TBA_WL_RST     = 17'd19661;

  typedef enum logic [2:0] {
    CFG_EQUAL      = 3'd0,
    CFG_FULL       = 3'd1,
    CFG_LIGHT      = 3'd2,
    CFG_STRICT     = 3'd3,
    CFG_W_COMPUTE  = 3'd4,
    CFG_W_AUTOGRAD = 3'd5,
    CFG_W_LOADER   = 3'd6
  } tba_cfg_idx_t;

  typedef enum logic [1:0] {
    GRP_COMPUTE  = 2'd0,
    GRP_AUTOGRAD = 2'd1,
    GRP_LOADER   = 2'd2
  } tba_grp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WSUM,
    ST_RMUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ALLOC,
    ST_STRICT,
    ST_LIGHT,
    ST_DONE
  } tba_state_t;

  typedef struct packed {
    logic [TBA_T_W-1:0] equal_threshold;
    logic [TBA_T_W-1:0] full_threshold;
    logic [TBA_T_W-1:0] light_threshold;
    logic [TBA_T_W-1:0] strict_threshold;
    logic [TBA_W_W-1:0] weight_compute;
    logic [TBA_W_W-1:0] weight_autograd;
    logic [TBA_W_W-1:0] weight_loader;
  } tba_cfg_t;

  typedef struct packed {
    logic                   done;
    logic [TBA_QUOT_W-1:0]  quot;
    logic [TBA_DEN_W-1:0]   rem;
  } tba_div_res_t;

  typedef struct packed {
    logic                 valid;
    logic                 error_flag;
    logic [TBA_SH_W-1:0]  compute_share;
    logic [TBA_SH_W-1:0]  autograd_share;
    logic [TBA_SH_W-1:0]  loader_share;
  } tba_res_t;

endpackage

FILE: src/tba_mul.sv
module tba_mul (
  input  logic                             clk,
  input  logic [tba_pkg::TBA_W_W-1:0]      a,
  input  logic [tba_pkg::TBA_WS_W-1:0]     b,
  output logic [tba_pkg::TBA_PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= tba_pkg::TBA_PROD_W'(a) * tba_pkg::TBA_PROD_W'(b);
  end

endmodule

FILE: src/tba_div.sv
module tba_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tba_pkg::TBA_NUM_W-1:0]     num,
  input  logic [tba_pkg::TBA_DEN_W-1:0]     den,
  output tba_pkg::tba_div_res_t             res
);

  localparam int QW = tba_pkg::TBA_QUOT_W;
  localparam int NW = tba_pkg::TBA_NUM_W;

  logic                              busy;
  logic                              done;
  logic [tba_pkg::TBA_CNT_W-1:0]     cnt;
  logic [NW-1:0]                     rem;
  logic [NW-1:0]                     dsh;
  logic [QW-1:0]                     quot;
  logic                              ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= tba_pkg::TBA_CNT_W'(QW - 1);
      rem  <= num;
      dsh  <= NW'(den) << (QW - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QW-2:0], ge};
      dsh  <= dsh >> 1;
      cnt  <= cnt - 1'b1;
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem[tba_pkg::TBA_DEN_W-1:0];

endmodule

FILE: src/tba_seq.sv
module tba_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  tba_pkg::tba_cfg_t               cfg,
  input  logic                            in_valid,
  input  logic [tba_pkg::TBA_T_W-1:0]     total_threads,
  output logic                            in_ready,
  input  logic                            res_ready,
  output tba_pkg::tba_res_t               res
);

  localparam int SW = tba_pkg::TBA_SH_W;
  localparam int TW = tba_pkg::TBA_T_W;
  localparam logic [SW-1:0] ONE = SW'(1);

  tba_pkg::tba_state_t state, state_next;

  logic [TW-1:0]                     t_reg;
  logic [TW-1:0]                     r;
  logic [TW-1:0]                     fn;
  logic [TW-1:0]                     fd;
  tba_pkg::tba_grp_t                 grp;
  logic [tba_pkg::TBA_WS_W-1:0]      ws;
  logic [tba_pkg::TBA_QUOT_W-1:0]    base [3];
  logic [tba_pkg::TBA_DEN_W-1:0]     rest [3];
  logic [SW-1:0]                     c, a, l;
  logic                              err;
  logic [tba_pkg::TBA_PASS_W-1:0]    pass_cnt;
  logic                              res_valid;

  logic [tba_pkg::TBA_W_W-1:0]       mul_a;
  logic [tba_pkg::TBA_WS_W-1:0]      mul_b;
  logic [tba_pkg::TBA_PROD_W-1:0]    prod;
  logic [tba_pkg::TBA_W_W-1:0]       w_sel;
  logic [tba_pkg::TBA_DEN_W-1:0]     den;
  logic                              div_start;
  tba_pkg::tba_div_res_t             div_res;

  logic [TW-1:0]                     fn_in, fd_in;
  logic [SW-1:0]                     base_sum;
  logic [TW-1:0]                     deficit;
  logic                              p01, p02, p21;
  logic [1:0]                        rank0, rank1, rank2;
  logic [SW-1:0]                     extra;
  logic [SW-1:0]                     sc1, sl1, sl2, sa2;
  logic                              strict_stop;
  logic [SW-1:0]                     ll2, la2, lc3, ll3, ll4, la4;

  tba_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  tba_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[tba_pkg::TBA_NUM_W-1:0]),
    .den   (den),
    .res   (div_res)
  );

  assign den = (tba_pkg::TBA_DEN_W'(fd) << 17) + (tba_pkg::TBA_DEN_W'(fd) << 16);

  always_comb begin
    case (grp)
      tba_pkg::GRP_COMPUTE:  w_sel = cfg.weight_compute;
      tba_pkg::GRP_AUTOGRAD: w_sel = cfg.weight_autograd;
      tba_pkg::GRP_LOADER:   w_sel = cfg.weight_loader;
      default:               w_sel = cfg.weight_compute;
    endcase
  end

  always_comb begin
    if (total_threads >= cfg.full_threshold) begin
      fn_in = TW'(1);
      fd_in = TW'(1);
    end else if (total_threads > cfg.equal_threshold) begin
      fn_in = total_threads - cfg.equal_threshold;
      fd_in = cfg.full_threshold - cfg.equal_threshold;
    end else begin
      fn_in = '0;
      fd_in = TW'(1);
    end
  end

  always_comb begin
    base_sum = SW'(base[0]) + SW'(base[1]) + SW'(base[2]);
    deficit  = (base_sum < SW'(r)) ? TW'(SW'(r) - base_sum) : '0;
    p01 = (rest[0] >= rest[1]);
    p02 = (rest[0] >= rest[2]);
    p21 = (rest[2] >= rest[1]);
    rank0 = 2'(!p01) + 2'(!p02);
    rank1 = 2'(p01) + 2'(p21);
    rank2 = 2'(p02) + 2'(!p21);
    extra = (deficit > TW'(3)) ? SW'(deficit - TW'(3)) : '0;
  end

  always_comb begin
    sc1 = c;
    sl1 = l;
    if (c <= l && l > ONE) begin
      sc1 = c + ONE;
      sl1 = l - ONE;
    end
    sl2 = sl1;
    sa2 = a;
    if (sl1 <= a && a > ONE) begin
      sl2 = sl1 + ONE;
      sa2 = a - ONE;
    end
    strict_stop = (sc1 > sl2) && (sl2 > sa2);

    ll2 = sl1;
    la2 = a;
    if (sl1 < a && a > ONE) begin
      ll2 = sl1 + ONE;
      la2 = a - ONE;
    end
    lc3 = sc1;
    ll3 = ll2;
    if (sc1 == ll2 && ll2 > ONE) begin
      lc3 = sc1 + ONE;
      ll3 = ll2 - ONE;
    end
    ll4 = ll3;
    la4 = la2;
    if (ll3 < la2 && la2 > ONE) begin
      ll4 = ll3 + ONE;
      la4 = la2 - ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    res_valid  = 1'b0;
    case (state)
      tba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (total_threads < TW'(4)) ? tba_pkg::ST_DONE : tba_pkg::ST_WMUL;
        end
      end
      tba_pkg::ST_WMUL: begin
        mul_a      = w_sel;
        mul_b      = tba_pkg::TBA_WS_W'(fn);
        state_next = tba_pkg::ST_WSUM;
      end
      tba_pkg::ST_WSUM: begin
        state_next = tba_pkg::ST_RMUL;
      end
      tba_pkg::ST_RMUL: begin
        mul_a      = tba_pkg::TBA_W_W'(r);
        mul_b      = ws;
        state_next = tba_pkg::ST_DIV_GO;
      end
      tba_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = tba_pkg::ST_DIV_WAIT;
      end
      tba_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_next = (grp == tba_pkg::GRP_LOADER) ? tba_pkg::ST_ALLOC : tba_pkg::ST_WMUL;
        end
      end
      tba_pkg::ST_ALLOC: begin
        if (t_reg >= cfg.strict_threshold) begin
          state_next = tba_pkg::ST_STRICT;
        end else if (t_reg >= cfg.light_threshold) begin
          state_next = tba_pkg::ST_LIGHT;
        end else begin
          state_next = tba_pkg::ST_DONE;
        end
      end
      tba_pkg::ST_STRICT: begin
        if (strict_stop ||
            pass_cnt == tba_pkg::TBA_PASS_W'(tba_pkg::TBA_ORDER_PASSES - 1)) begin
          state_next = tba_pkg::ST_DONE;
        end
      end
      tba_pkg::ST_LIGHT: begin
        state_next = tba_pkg::ST_DONE;
      end
      tba_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = tba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tba_pkg::ST_IDLE: begin
        t_reg    <= total_threads;
        r        <= total_threads - TW'(3);
        fn       <= fn_in;
        fd       <= fd_in;
        grp      <= tba_pkg::GRP_COMPUTE;
        pass_cnt <= '0;
        err      <= (total_threads < TW'(2));
        c        <= (total_threads < TW'(2)) ? '0 : ONE;
        a        <= (total_threads < TW'(2)) ? '0 : ONE;
        l        <= (total_threads < TW'(2)) ? '0 : ONE;
      end
      tba_pkg::ST_WSUM: begin
        ws <= (tba_pkg::TBA_WS_W'(fd - fn) << 16)
            + tba_pkg::TBA_WS_W'(prod[32:0])
            + (tba_pkg::TBA_WS_W'(prod[32:0]) << 1);
      end
      tba_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          base[grp] <= div_res.quot;
          rest[grp] <= div_res.rem;
          case (grp)
            tba_pkg::GRP_COMPUTE:  grp <= tba_pkg::GRP_AUTOGRAD;
            tba_pkg::GRP_AUTOGRAD: grp <= tba_pkg::GRP_LOADER;
            default:               grp <= tba_pkg::GRP_COMPUTE;
          endcase
        end
      end
      tba_pkg::ST_ALLOC: begin
        c <= SW'(base[0]) + ONE + SW'(deficit > TW'(rank0)) + extra;
        a <= SW'(base[1]) + ONE + SW'(deficit > TW'(rank1));
        l <= SW'(base[2]) + ONE + SW'(deficit > TW'(rank2));
      end
      tba_pkg::ST_STRICT: begin
        c        <= sc1;
        l        <= sl2;
        a        <= sa2;
        pass_cnt <= pass_cnt + 1'b1;
      end
      tba_pkg::ST_LIGHT: begin
        c <= lc3;
        l <= ll4;
        a <= la4;
      end
      default: begin
      end
    endcase
  end

  assign res.valid          = res_valid;
  assign res.error_flag     = err;
  assign res.compute_share  = c;
  assign res.autograd_share = a;
  assign res.loader_share   = l;

endmodule

FILE: src/thread_budget_apportioner.sv
// Thread budget apportioner.
// A total thread count arrives as one transaction on the s_axis channel and
// leaves as one transaction on the m_axis channel, holding the compute,
// autograd and data loader budgets and, in tuser, an error flag for totals
// below two. The seven registers of the cfg channel (thresholds and Q1.16
// target weights) are written with cfg_valid and cfg_ready, which is always
// high; they should be written only while no transaction is in flight.
// A total of three or less goes from the idle state straight to the done state.
// Larger totals run the arithmetic: for each of the three groups one shared
// multiplier is used twice and one shared restoring divider runs 18 iterations,
// followed by one allocation step and up to ten passes of the strict ordering
// (or one light ordering step). One transaction is worked on at a time;
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new input transaction can be
// taken while the receiver stalls; the following result then waits until the
// output register is free.
// Reset clears the sequencer and the output valid and loads the register
// defaults.
module thread_budget_apportioner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] total_threads
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] compute_share, [31:16] autograd_share, [47:32] loader_share
  output logic [47:0] m_axis_tdata,
  // [0] error_flag
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int SW = tba_pkg::TBA_SH_W;

  tba_pkg::tba_cfg_t  cfg;
  tba_pkg::tba_res_t  res;
  logic               res_ready;
  logic [15:0]        compute_share, autograd_share, loader_share;
  logic               error_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.equal_threshold  <= tba_pkg::TBA_EQUAL_RST;
      cfg.full_threshold   <= tba_pkg::TBA_FULL_RST;
      cfg.light_threshold  <= tba_pkg::TBA_LIGHT_RST;
      cfg.strict_threshold <= tba_pkg::TBA_STRICT_RST;
      cfg.weight_compute   <= tba_pkg::TBA_WC_RST;
      cfg.weight_autograd  <= tba_pkg::TBA_WA_RST;
      cfg.weight_loader    <= tba_pkg::TBA_WL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tba_pkg::CFG_EQUAL:      cfg.equal_threshold  <= cfg_data[15:0];
        tba_pkg::CFG_FULL:       cfg.full_threshold   <= cfg_data[15:0];
        tba_pkg::CFG_LIGHT:      cfg.light_threshold  <= cfg_data[15:0];
        tba_pkg::CFG_STRICT:     cfg.strict_threshold <= cfg_data[15:0];
        tba_pkg::CFG_W_COMPUTE:  cfg.weight_compute   <= cfg_data;
        tba_pkg::CFG_W_AUTOGRAD: cfg.weight_autograd  <= cfg_data;
        tba_pkg::CFG_W_LOADER:   cfg.weight_loader    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tba_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .total_threads (s_axis_tdata),
    .in_ready      (s_axis_tready),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      compute_share  <= (res.compute_share > SW'(16'hFFFF)) ? 16'hFFFF
                                                            : res.compute_share[15:0];
      autograd_share <= (res.autograd_share > SW'(16'hFFFF)) ? 16'hFFFF
                                                              : res.autograd_share[15:0];
      loader_share   <= (res.loader_share > SW'(16'hFFFF)) ? 16'hFFFF
                                                          : res.loader_share[15:0];
      error_flag     <= res.error_flag;
    end
  end

  assign m_axis_tdata = {loader_share, autograd_share, compute_share};
  assign m_axis_tuser = error_flag;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 48'd0))
    else $error("error result carries nonzero shares");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[31:16] != 16'd0 &&
       m_axis_tdata[47:32] != 16'd0))
    else $error("successful result has an empty group");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while a total is being split");

endmodule

FILE: tb/sv/thread_budget_apportioner_tb.sv
`timescale 1ns / 1ps

module thread_budget_apportioner_tb;

  typedef struct packed {
    logic        error_flag;
    logic [15:0] loader_share;
    logic [15:0] autograd_share;
    logic [15:0] compute_share;
  } split_t;

  class budget_scoreboard;
    tba_pkg::tba_cfg_t cfg;
    split_t            expected_splits[$];
    int unsigned       failures;

    function new();
      cfg.equal_threshold  = tba_pkg::TBA_EQUAL_RST;
      cfg.full_threshold   = tba_pkg::TBA_FULL_RST;
      cfg.light_threshold  = tba_pkg::TBA_LIGHT_RST;
      cfg.strict_threshold = tba_pkg::TBA_STRICT_RST;
      cfg.weight_compute   = tba_pkg::TBA_WC_RST;
      cfg.weight_autograd  = tba_pkg::TBA_WA_RST;
      cfg.weight_loader    = tba_pkg::TBA_WL_RST;
      failures = 0;
    endfunction

    function void set_reg(tba_pkg::tba_cfg_idx_t idx, logic [16:0] value);
      case (idx)
        tba_pkg::CFG_EQUAL:      cfg.equal_threshold  = value[15:0];
        tba_pkg::CFG_FULL:       cfg.full_threshold   = value[15:0];
        tba_pkg::CFG_LIGHT:      cfg.light_threshold  = value[15:0];
        tba_pkg::CFG_STRICT:     cfg.strict_threshold = value[15:0];
        tba_pkg::CFG_W_COMPUTE:  cfg.weight_compute   = value;
        tba_pkg::CFG_W_AUTOGRAD: cfg.weight_autograd  = value;
        tba_pkg::CFG_W_LOADER:   cfg.weight_loader    = value;
        default: ;
      endcase
    endfunction

    function split_t apportion(logic [15:0] total);
      split_t            s;
      longint unsigned   t, r, fn, fd, den, num, best_rem, sum, deficit, c, a, l;
      longint unsigned   w[3];
      longint unsigned   rem[3];
      longint unsigned   base[3];
      tba_pkg::tba_grp_t pick[3];
      tba_pkg::tba_grp_t best;
      bit                found;
      bit                given[3];
      s = '0;
      t = total;
      if (t < 2) begin
        s.error_flag = 1'b1;
        return s;
      end
      if (t <= 3) begin
        s.compute_share  = 16'd1;
        s.autograd_share = 16'd1;
        s.loader_share   = 16'd1;
        return s;
      end
      r = t - 3;
      if (t >= cfg.full_threshold) begin
        fn = 1;
        fd = 1;
      end else if (t > cfg.equal_threshold) begin
        fn = t - cfg.equal_threshold;
        fd = cfg.full_threshold - cfg.equal_threshold;
      end else begin
        fn = 0;
        fd = 1;
      end
      w[tba_pkg::GRP_COMPUTE]  = cfg.weight_compute;
      w[tba_pkg::GRP_AUTOGRAD] = cfg.weight_autograd;
      w[tba_pkg::GRP_LOADER]   = cfg.weight_loader;
      // Shares are exact rationals over 3 * 65536 * fd.
      den = 64'd196608 * fd;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        num = r * (64'd65536 * (fd - fn) + 64'd3 * w[k] * fn);
        base[k] = num / den;
        rem[k] = num % den;
        sum += base[k];
      end
      deficit = (sum < r) ? r - sum : 0;
      // Tie order is compute, then loader, then autograd.
      pick = '{tba_pkg::GRP_COMPUTE, tba_pkg::GRP_LOADER, tba_pkg::GRP_AUTOGRAD};
      given = '{default: 1'b0};
      for (longint unsigned k = 0; k < deficit; k++) begin
        found = 1'b0;
        best = tba_pkg::GRP_COMPUTE;
        best_rem = 0;
        for (int p = 0; p < 3; p++) begin
          if (!given[pick[p]] && (!found || rem[pick[p]] > best_rem)) begin
            best = pick[p];
            best_rem = rem[pick[p]];
            found = 1'b1;
          end
        end
        if (!found) begin
          base[tba_pkg::GRP_COMPUTE] += deficit - k;
          break;
        end
        given[best] = 1'b1;
        base[best] += 1;
      end
      c = base[tba_pkg::GRP_COMPUTE] + 1;
      a = base[tba_pkg::GRP_AUTOGRAD] + 1;
      l = base[tba_pkg::GRP_LOADER] + 1;
      if (t >= cfg.strict_threshold) begin
        for (int k = 0; k < tba_pkg::TBA_ORDER_PASSES; k++) begin
          if (c <= l && l > 1) begin
            c++;
            l--;
          end
          if (l <= a && a > 1) begin
            l++;
            a--;
          end
          if (c > l && l > a) break;
        end
      end else if (t >= cfg.light_threshold) begin
        if (c <= l && l > 1) begin
          c++;
          l--;
        end
        if (l < a && a > 1) begin
          l++;
          a--;
        end
        if (c == l && l > 1) begin
          c++;
          l--;
        end
        if (l < a && a > 1) begin
          l++;
          a--;
        end
      end
      s.compute_share  = (c > 65535) ? 16'hFFFF : 16'(c);
      s.autograd_share = (a > 65535) ? 16'hFFFF : 16'(a);
      s.loader_share   = (l > 65535) ? 16'hFFFF : 16'(l);
      return s;
    endfunction

    function void note_total(logic [15:0] total);
      expected_splits.push_back(apportion(total));
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_split(logic [47:0] data, logic [0:0] user);
      split_t want;
      if (expected_splits.size() == 0) begin
        $error("result transaction with nothing pending: data %h user %b", data, user);
        failures++;
        return;
      end
      want = expected_splits.pop_front();
      compare("compute_share", want.compute_share, data[15:0]);
      compare("autograd_share", want.autograd_share, data[31:16]);
      compare("loader_share", want.loader_share, data[47:32]);
      compare("error_flag", {15'd0, want.error_flag}, {15'd0, user[0]});
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  tba_pkg::tba_cfg_idx_t cfg_index = tba_pkg::CFG_EQUAL;
  logic [16:0]           cfg_data = '0;

  budget_scoreboard sb = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  thread_budget_apportioner u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic write_reg(tba_pkg::tba_cfg_idx_t idx, logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic load_config(logic [15:0] eq_t, full_t, light_t, strict_t,
                             logic [16:0] wc, wa, wl);
    write_reg(tba_pkg::CFG_EQUAL, {1'b0, eq_t});
    write_reg(tba_pkg::CFG_FULL, {1'b0, full_t});
    write_reg(tba_pkg::CFG_LIGHT, {1'b0, light_t});
    write_reg(tba_pkg::CFG_STRICT, {1'b0, strict_t});
    write_reg(tba_pkg::CFG_W_COMPUTE, wc);
    write_reg(tba_pkg::CFG_W_AUTOGRAD, wa);
    write_reg(tba_pkg::CFG_W_LOADER, wl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_threshold();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 48));
  endfunction

  task automatic random_config();
    logic [16:0] wc, wa, wl;
    if ($urandom_range(0, 9) < 7) begin
      wc = 17'($urandom_range(0, 65536));
      wa = 17'($urandom_range(0, 65536 - wc));
      wl = 17'd65536 - wc - wa;
    end else begin
      wc = 17'($urandom_range(0, 65536));
      wa = 17'($urandom_range(0, 65536));
      wl = 17'($urandom_range(0, 65536));
    end
    load_config(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold(),
                wc, wa, wl);
  endtask

  function automatic logic [15:0] pick_total();
    int unsigned sel;
    int          thr;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($urandom_range(0, 40));
    if (sel < 7) begin
      case ($urandom_range(0, 3))
        0: thr = sb.cfg.equal_threshold;
        1: thr = sb.cfg.full_threshold;
        2: thr = sb.cfg.light_threshold;
        default: thr = sb.cfg.strict_threshold;
      endcase
      thr = thr + int'($urandom_range(0, 6)) - 3;
      if (thr < 0) thr = 0;
      if (thr > 65535) thr = 65535;
      return 16'(thr);
    end
    if (sel < 9) return 16'($urandom_range(0, 1000));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_total(logic [15:0] total);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= total;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_total(total);
  endtask

  task automatic settle(int unsigned tail);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_splits.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    logic [15:0] corner_totals[$];
    corner_totals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6,
                      16'd7, 16'd8, 16'd9, 16'd10, 16'd12, 16'd20,
                      16'd31, 16'd32, 16'd33, 16'd100, 16'd4096,
                      16'd32768, 16'd65534, 16'd65535};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_totals[i]) send_total(corner_totals[i]);
    for (int ph = 1; ph <= 12; ph++) begin
      settle(4);
      case (ph)
        1: load_config(16'd0, 16'd0, 16'd0, 16'd0, 17'd65536, 17'd0, 17'd0);
        2: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd0, 17'd0, 17'd65536);
        3: load_config(16'd4, 16'd20, 16'd5, 16'd10, 17'd0, 17'd0, 17'd0);
        4: load_config(16'd2, 16'd40, 16'd3, 16'd12, 17'd65536, 17'd65536, 17'd65536);
        5: load_config(tba_pkg::TBA_EQUAL_RST, tba_pkg::TBA_FULL_RST,
                       tba_pkg::TBA_LIGHT_RST, tba_pkg::TBA_STRICT_RST,
                       17'd21845, 17'd21846, 17'd21845);
        default: random_config();
      endcase
      tx_calm = (ph % 4 == 2) || (ph == 8);
      rx_calm = (ph % 4 == 3) || (ph == 8);
      repeat (95) send_total(pick_total());
    end
    settle(100);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!m_axis_tvalid);
        end
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_split(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: thread_budget_apportioner.f
src/tba_pkg.sv
src/tba_mul.sv
src/tba_div.sv
src/tba_seq.sv
src/thread_budget_apportioner.sv
tb/sv/thread_budget_apportioner_tb.sv
